FILE: hw/rtl/dnv_pkg.sv
package dnv_pkg;

	// Limits of the name and of one label
	localparam int unsigned MAX_NAME_LEN  = 253;
	localparam int unsigned MAX_LABEL_LEN = 63;
	localparam int unsigned NAME_CAP_RAW  = MAX_NAME_LEN + 1;
	localparam int unsigned NAME_CAP      = (NAME_CAP_RAW > 511) ? 511 : NAME_CAP_RAW;
	localparam int unsigned NAME_LEN_W    = 9;
	localparam int unsigned LABEL_LEN_W   = 6;

	// Verdict codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_LONG  = 2'd1;
	localparam logic [1:0] ERR_CHAR  = 2'd2;
	localparam logic [1:0] ERR_LABEL = 2'd3;

	// Special characters
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_Z     = 8'h7A;

	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       last;
		logic       allow_wildcard;
	} chr_item_t;

	typedef struct packed {
		logic       name_ok;
		logic [1:0] error_code;
	} vrd_item_t;

	typedef struct packed {
		logic [NAME_LEN_W-1:0]  name_length;
		logic [LABEL_LEN_W-1:0] label_length;
		logic [1:0]             first_error;
		logic                   star_pending;
		logic                   wildcard_latched;
	} dnv_state_t;

	localparam dnv_state_t STATE_RESET = '{
		name_length:      '0,
		label_length:     '0,
		first_error:      ERR_NONE,
		star_pending:     1'b0,
		wildcard_latched: 1'b0
	};

endpackage

FILE: hw/rtl/dnv_core.sv
module dnv_core (
	input  dnv_pkg::dnv_state_t cur,
	input  dnv_pkg::chr_item_t  item,
	output dnv_pkg::dnv_state_t nxt,
	output logic                done,
	output dnv_pkg::vrd_item_t  verdict
);
	import dnv_pkg::*;

	localparam logic [NAME_LEN_W-1:0]  NAME_CAP_V  = NAME_CAP[NAME_LEN_W-1:0];
	localparam logic [NAME_LEN_W-1:0]  NAME_MAX_V  = MAX_NAME_LEN[NAME_LEN_W-1:0];
	localparam logic [LABEL_LEN_W-1:0] LABEL_MAX_V = MAX_LABEL_LEN[LABEL_LEN_W-1:0];

	logic                   allowed;
	logic                   is_dot;
	logic [1:0]             err_v;
	logic [NAME_LEN_W-1:0]  prefix;

	// Character class
	always_comb begin
		allowed = (item.char_code == CH_DASH) || (item.char_code == CH_UNDER) ||
			((item.char_code >= CH_0) && (item.char_code <= CH_9)) ||
			((item.char_code >= CH_A) && (item.char_code <= CH_Z));
		is_dot = (item.char_code == CH_DOT);
	end

	// Next state for one item
	always_comb begin
		nxt = cur;
		if (item.has_char) begin
			if (cur.name_length < NAME_CAP_V)
				nxt.name_length = cur.name_length + 1'b1;
			if ((cur.name_length == '0) && item.allow_wildcard &&
				(item.char_code == CH_STAR)) begin
				nxt.star_pending = 1'b1;
			end else if (cur.star_pending) begin
				nxt.star_pending = 1'b0;
				if (is_dot)
					nxt.wildcard_latched = 1'b1;
				else if (cur.first_error == ERR_NONE)
					nxt.first_error = ERR_CHAR; // star as a plain char is illegal
			end else if (cur.first_error == ERR_NONE) begin
				if (allowed) begin
					if (cur.label_length >= LABEL_MAX_V)
						nxt.first_error = ERR_LABEL;
					else
						nxt.label_length = cur.label_length + 1'b1;
				end else if (is_dot) begin
					if (cur.label_length == '0)
						nxt.first_error = ERR_LABEL;
					else
						nxt.label_length = '0;
				end else begin
					nxt.first_error = ERR_CHAR;
				end
			end
		end
	end

	// Verdict from the updated state
	always_comb begin
		done   = !item.has_char || item.last;
		prefix = nxt.wildcard_latched ? NAME_LEN_W'(2) : '0;
		err_v  = nxt.first_error;
		if ((err_v == ERR_NONE) && !nxt.star_pending && (nxt.label_length == '0) &&
			(nxt.name_length > prefix))
			err_v = ERR_LABEL; // trailing dot
		if (nxt.name_length > NAME_MAX_V)
			err_v = ERR_LONG;
		verdict.name_ok    = (err_v == ERR_NONE);
		verdict.error_code = err_v;
	end

endmodule

FILE: hw/rtl/domain_name_validator_unit.sv
// Domain name syntax check, one character item per clock when not stalled.
// The verdict item appears in the cycle after the item ending the name is taken.
// Throughput: one character item per cycle unless stalled; the per-item update
// is a single pass of counter and flag logic between state and verdict registers.
// Reset: arst_n clears all name state and the verdict valid flag at once.
module domain_name_validator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  dnv_pkg::chr_item_t char_item,
	output logic               verdict_valid,
	input  logic               verdict_stall,
	output dnv_pkg::vrd_item_t verdict_item
);
	import dnv_pkg::*;

	dnv_state_t state_q;
	dnv_state_t state_nxt;
	logic       done;
	vrd_item_t  verdict;
	logic       accept;
	logic       vld_q;
	vrd_item_t  vrd_q;

	// Hold off input only while a verdict waits
	assign char_stall = vld_q && verdict_stall;
	assign accept     = char_valid && !char_stall;

	dnv_core u_core (
		.cur     (state_q),
		.item    (char_item),
		.nxt     (state_nxt),
		.done    (done),
		.verdict (verdict)
	);

	// Name state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= done ? STATE_RESET : state_nxt;
		end
	end

	// Verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!char_stall) begin
			vld_q <= accept && done;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && done)
			vrd_q <= verdict;
	end

	assign verdict_valid = vld_q;
	assign verdict_item  = vrd_q;

endmodule

FILE: hw/rtl/dnv_checker.sv
module dnv_sva_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               char_valid,
	input logic               char_stall,
	input dnv_pkg::chr_item_t char_item,
	input logic               verdict_valid,
	input logic               verdict_stall,
	input dnv_pkg::vrd_item_t verdict_item
);
	import dnv_pkg::*;

	// A waiting verdict holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict_item))
		else $error("verdict item changed while stalled");

	// Input is held off only by a waiting verdict
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> verdict_valid && verdict_stall)
		else $error("input stalled with no verdict waiting");

	// The ok flag agrees with the code
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict_item.name_ok == (verdict_item.error_code == ERR_NONE)))
		else $error("name_ok disagrees with error_code");

	// An item ending the name yields a verdict next cycle
	a_end_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && (!char_item.has_char || char_item.last)
		|=> verdict_valid)
		else $error("missing verdict after end of name");

	// A mid-name character yields no verdict
	a_mid_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && char_item.has_char && !char_item.last &&
		!(verdict_valid && verdict_stall) |=> !verdict_valid)
		else $error("verdict in the middle of a name");

endmodule

bind domain_name_validator_unit dnv_sva_checker u_dnv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.char_valid    (char_valid),
	.char_stall    (char_stall),
	.char_item     (char_item),
	.verdict_valid (verdict_valid),
	.verdict_stall (verdict_stall),
	.verdict_item  (verdict_item)
);
